// File: rtl/core/dcm_pkg.sv
// Shared types, constants and codes of the DC motor step unit.
package dcm_pkg;

   // Fixed-point format of all physical quantities
   localparam int FRAC_BITS = 16;
   localparam int FRACM_W   = FRAC_BITS + 1;   // width of a factor in [0, 1]

   // Field widths
   localparam int V_W     = 24;
   localparam int OUT_W   = 32;
   localparam int RV_W    = 23;
   localparam int RPM_W   = 15;
   localparam int ST_W    = 21;
   localparam int TS_W    = 17;
   localparam int CSR_IW  = 3;
   localparam int CSR_DW  = 23;

   // Shared arithmetic unit
   localparam int ALU_W = 66;
   localparam int CNT_W = 6;

   // Fixed-point constants
   localparam logic [FRACM_W-1:0] ONE_Q   = FRACM_W'(1 << FRAC_BITS);
   localparam logic [FRACM_W-1:0] COAST_Q = FRACM_W'(((95 << FRAC_BITS) + 50) / 100);
   localparam logic [FRACM_W-1:0] DAMP_Q  = FRACM_W'(((99 << FRAC_BITS) + 50) / 100);
   localparam logic [28:0]        RAD_PER_RPM_Q32 = 29'd449767923;   // 2*pi/60, Q0.32
   localparam logic [OUT_W-1:0]   EPS_Q   = OUT_W'(((1 << FRAC_BITS) + 500000) / 1000000);
   localparam logic [30:0]        POS_MAX = 31'h7FFF_FFFF;
   localparam logic [9:0]         INV_INERTIA = 10'd1000;

   // Register reset values
   localparam logic [RV_W-1:0]  RATED_V_RST = RV_W'(786432);
   localparam logic [RPM_W-1:0] RPM_RST     = RPM_W'(6000);
   localparam logic [ST_W-1:0]  STALL_RST   = ST_W'(6554);
   localparam logic [TS_W-1:0]  TSTEP_RST   = TS_W'(1092);

   typedef enum logic [CSR_IW-1:0] {
      CSR_ENABLE    = 3'd0,
      CSR_RATED_V   = 3'd1,
      CSR_NL_RPM    = 3'd2,
      CSR_STALL     = 3'd3,
      CSR_TIME_STEP = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic             enable;
      logic [RV_W-1:0]  rated_voltage;
      logic [RPM_W-1:0] no_load_speed_rpm;
      logic [ST_W-1:0]  stall_nm;
      logic [TS_W-1:0]  time_step;
   } cfg_type;

   typedef enum logic {
      ALU_MUL = 1'b0,
      ALU_DIV = 1'b1
   } alu_op_type;

   // mul: x * y over nbits of y; div: x (MSB aligned, nbits long) / y
   typedef struct packed {
      logic             start;
      alu_op_type       op;
      logic [ALU_W-1:0] x;
      logic [ALU_W-1:0] y;
      logic [CNT_W-1:0] nbits;
   } alu_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [ALU_W-1:0] result;
   } alu_stat_type;

endpackage

// File: rtl/core/dcm_if.sv
// Valid/ready channels of the DC motor step unit.
interface dcm_req_if;
   import dcm_pkg::*;

   logic                  valid;
   logic                  ready;
   logic signed [V_W-1:0] voltage_difference;

   modport source (output valid, output voltage_difference, input ready);
   modport sink   (input valid, input voltage_difference, output ready);
endinterface

interface dcm_rsp_if;
   import dcm_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] shaft_speed_out;
   logic signed [OUT_W-1:0] shaft_angle_out;
   logic signed [OUT_W-1:0] torque_out;

   modport source (output valid, output shaft_speed_out, output shaft_angle_out,
                   output torque_out, input ready);
   modport sink   (input valid, input shaft_speed_out, input shaft_angle_out,
                   input torque_out, output ready);
endinterface

// File: rtl/core/dc_motor_model_step_unit.sv
// DC motor step unit top level: handshake, step sequencer and motor state.
//
// Each request transaction carries one terminal voltage (signed Q8.16) and
// advances a DC motor with a linear torque-speed curve by one time step; each
// yields exactly one response transaction with the new shaft speed, the new
// wrapped shaft angle and the torque of the step. All arithmetic runs through
// one bit-serial multiply/divide unit, one operand bit per cycle. A driven
// step runs three long divides and eight multiplies; fewer run when the
// torque term is off (zero rpm or a vanishing no-load speed) or the rated
// voltage is zero, a coast step (zero voltage) runs one multiply and a
// disabled step runs none.
// req_ch.ready is high only while no step is in flight; a finished
// response waits in an output register, so the next request can be taken
// before the last response is consumed. Configuration is written through
// csr_we/csr_index/csr_wdata and should only change while the unit is idle;
// enable = 0 freezes speed and angle and returns them with zero torque.
module dc_motor_model_step_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [dcm_pkg::CSR_IW-1:0] csr_index,
   input  logic [dcm_pkg::CSR_DW-1:0] csr_wdata,
   dcm_req_if.sink                    req_ch,
   dcm_rsp_if.source                  rsp_ch
);
   import dcm_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NL_MUL,    // rpm * |v|
      ST_NL_DIV,    // / rated voltage
      ST_RAD_MUL,   // * 2pi/60 -> no-load speed limit
      ST_STL_MUL,   // stall torque * |v|
      ST_STL_DIV,   // / rated voltage
      ST_RT_DIV,    // |speed| / no-load speed
      ST_MAG_MUL,   // stall * (1 - ratio) -> torque
      ST_T1K_MUL,   // torque / inertia
      ST_TTS_MUL,   // * time step -> speed delta
      ST_DMP_MUL,   // damping and clamp
      ST_ANG_MUL,   // speed * time step -> angle
      ST_CST_MUL,   // coast
      ST_DONE
   } state_type;

   localparam int NL_PROD_W = RPM_W + V_W;
   localparam int ST_PROD_W = ST_W + V_W;
   localparam int NL_A_W    = 36;           // rpm quotient, capped at 2^35
   localparam int DV_W      = 42;           // speed delta magnitude
   localparam int SUM_W     = 44;

   cfg_type      cfg;
   alu_req_type  alu_req;
   alu_stat_type alu_stat;

   state_type                state_ff;
   logic                     issued_ff;
   logic [V_W-1:0]           av_ff;
   logic                     vneg_ff;
   logic [30:0]              omega_ff;
   logic [30:0]              stallv_ff;
   logic [30:0]              mag_ff;
   logic signed [OUT_W-1:0]  torque_ff;
   logic signed [OUT_W-1:0]  spd_ff;
   logic signed [OUT_W-1:0]  speed_ff;
   logic signed [OUT_W-1:0]  angle_ff;
   logic                     rsp_valid_ff;
   logic signed [OUT_W-1:0]  rsp_speed_ff;
   logic signed [OUT_W-1:0]  rsp_angle_ff;
   logic signed [OUT_W-1:0]  rsp_torque_ff;

   logic                     req_fire;
   logic [V_W-1:0]           av_new;
   logic [ALU_W-1:0]         res;
   logic [NL_A_W-1:0]        nl_a_cap;
   logic [ALU_W-33:0]        omega_hi;
   logic [30:0]              omega_cap;
   logic [30:0]              stallv_cap;
   logic [FRACM_W-1:0]       ratio_cap;
   logic [OUT_W-1:0]         speed_abs;
   logic [OUT_W-1:0]         spd_abs;
   logic [OUT_W-1:0]         frac_p;       // product with the fraction dropped
   logic [DV_W-1:0]          dv_mag;
   logic signed [SUM_W-1:0]  dv_s;
   logic signed [SUM_W-1:0]  sum_s;
   logic signed [OUT_W-1:0]  spd_sat;
   logic signed [OUT_W:0]    dmp_s;
   logic signed [OUT_W:0]    omg_s;
   logic signed [OUT_W-1:0]  dmp_clamped;
   logic                     torque_on;

   dcm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dcm_alu u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .stat  (alu_stat)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.shaft_speed_out = rsp_speed_ff;
   assign rsp_ch.shaft_angle_out = rsp_angle_ff;
   assign rsp_ch.torque_out      = rsp_torque_ff;

   // Datapath around the shared unit
   always_comb begin
      res    = alu_stat.result;
      av_new = req_ch.voltage_difference[V_W-1] ?
               (~req_ch.voltage_difference + 1'b1) : req_ch.voltage_difference;

      nl_a_cap  = (res > ALU_W'(64'd1 << 35)) ? NL_A_W'(64'd1 << 35) : res[NL_A_W-1:0];
      omega_hi  = res[ALU_W-1:32];
      omega_cap = (omega_hi > (ALU_W-32)'(POS_MAX)) ? POS_MAX : omega_hi[30:0];
      stallv_cap = (res > ALU_W'(POS_MAX)) ? POS_MAX : res[30:0];
      ratio_cap = (res > ALU_W'(ONE_Q)) ? ONE_Q : res[FRACM_W-1:0];

      speed_abs = speed_ff[OUT_W-1] ? (~speed_ff + 1'b1) : speed_ff;
      spd_abs   = spd_ff[OUT_W-1] ? (~spd_ff + 1'b1) : spd_ff;
      frac_p    = res[FRAC_BITS+OUT_W-1:FRAC_BITS];

      // speed + torque*1000*dt, saturated to 32 bits
      dv_mag = res[FRAC_BITS+DV_W-1:FRAC_BITS];
      dv_s   = vneg_ff ? -$signed({2'b00, dv_mag}) : $signed({2'b00, dv_mag});
      sum_s  = $signed({{(SUM_W-OUT_W){speed_ff[OUT_W-1]}}, speed_ff}) + dv_s;
      if (sum_s > $signed(SUM_W'(32'h7FFF_FFFF)))
         spd_sat = 32'sh7FFF_FFFF;
      else if (sum_s < -$signed(SUM_W'(33'h0_8000_0000)))
         spd_sat = 32'sh8000_0000;
      else
         spd_sat = sum_s[OUT_W-1:0];

      // damped speed, clamped to the no-load speed limit
      dmp_s = spd_ff[OUT_W-1] ? -$signed({1'b0, frac_p}) : $signed({1'b0, frac_p});
      omg_s = $signed({2'b00, omega_ff});
      if (dmp_s > omg_s)
         dmp_clamped = omg_s[OUT_W-1:0];
      else if (dmp_s < -omg_s)
         dmp_clamped = -omg_s[OUT_W-1:0];
      else
         dmp_clamped = dmp_s[OUT_W-1:0];

      torque_on = (OUT_W'(av_ff) >= EPS_Q) && (cfg.no_load_speed_rpm != '0) &&
                  (OUT_W'(omega_cap) > EPS_Q);
   end

   // Operand selection for the shared unit
   always_comb begin
      alu_req.start = 1'b0;
      alu_req.op    = ALU_MUL;
      alu_req.x     = '0;
      alu_req.y     = '0;
      alu_req.nbits = CNT_W'(FRACM_W);
      case (state_ff)
         ST_NL_MUL: begin
            alu_req.x     = ALU_W'(cfg.no_load_speed_rpm);
            alu_req.y     = ALU_W'(av_ff);
            alu_req.nbits = CNT_W'(V_W);
         end
         ST_NL_DIV: begin
            alu_req.op    = ALU_DIV;
            alu_req.x     = {res[NL_PROD_W-1:0], {(ALU_W-NL_PROD_W){1'b0}}};
            alu_req.y     = ALU_W'(cfg.rated_voltage);
            alu_req.nbits = CNT_W'(NL_PROD_W);
         end
         ST_RAD_MUL: begin
            alu_req.x     = ALU_W'(RAD_PER_RPM_Q32);
            alu_req.y     = ALU_W'(nl_a_cap);
            alu_req.nbits = CNT_W'(NL_A_W);
         end
         ST_STL_MUL: begin
            alu_req.x     = ALU_W'(cfg.stall_nm);
            alu_req.y     = ALU_W'(av_ff);
            alu_req.nbits = CNT_W'(V_W);
         end
         ST_STL_DIV: begin
            alu_req.op    = ALU_DIV;
            alu_req.x     = {res[ST_PROD_W-1:0], {(ALU_W-ST_PROD_W){1'b0}}};
            alu_req.y     = ALU_W'(cfg.rated_voltage);
            alu_req.nbits = CNT_W'(ST_PROD_W);
         end
         ST_RT_DIV: begin
            alu_req.op    = ALU_DIV;
            alu_req.x     = {speed_abs, {(ALU_W-OUT_W){1'b0}}};
            alu_req.y     = ALU_W'(omega_ff);
            alu_req.nbits = CNT_W'(OUT_W + FRAC_BITS);
         end
         ST_MAG_MUL: begin
            alu_req.x = ALU_W'(stallv_ff);
            alu_req.y = ALU_W'(ONE_Q - ratio_cap);
         end
         ST_T1K_MUL: begin
            alu_req.x     = ALU_W'(mag_ff);
            alu_req.y     = ALU_W'(INV_INERTIA);
            alu_req.nbits = CNT_W'($bits(INV_INERTIA));
         end
         ST_TTS_MUL: begin
            alu_req.x     = res;
            alu_req.y     = ALU_W'(cfg.time_step);
            alu_req.nbits = CNT_W'(TS_W);
         end
         ST_DMP_MUL: begin
            alu_req.x = ALU_W'(spd_abs);
            alu_req.y = ALU_W'(DAMP_Q);
         end
         ST_ANG_MUL: begin
            alu_req.x     = ALU_W'(speed_abs);
            alu_req.y     = ALU_W'(cfg.time_step);
            alu_req.nbits = CNT_W'(TS_W);
         end
         ST_CST_MUL: begin
            alu_req.x = ALU_W'(speed_abs);
            alu_req.y = ALU_W'(COAST_Q);
         end
         default: ;
      endcase
      // every op state issues once on entry
      if (!(state_ff inside {ST_IDLE, ST_DONE}))
         alu_req.start = !issued_ff;
   end

   // Step sequencer and motor state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         speed_ff     <= '0;
         angle_ff     <= '0;
      end else begin
         // a response loaded in ST_DONE takes over the register instead
         if (rsp_valid_ff && rsp_ch.ready && (state_ff != ST_DONE))
            rsp_valid_ff <= 1'b0;

         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  av_ff     <= av_new;
                  vneg_ff   <= req_ch.voltage_difference[V_W-1];
                  torque_ff <= '0;
                  mag_ff    <= '0;
                  omega_ff  <= '0;
                  if (!cfg.enable)
                     state_ff <= ST_DONE;
                  else if (req_ch.voltage_difference == '0)
                     state_ff <= ST_CST_MUL;
                  else if (cfg.rated_voltage == '0)
                     state_ff <= ST_T1K_MUL;   // no torque, speed clamped to zero
                  else
                     state_ff <= ST_NL_MUL;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_speed_ff  <= speed_ff;
                  rsp_angle_ff  <= angle_ff;
                  rsp_torque_ff <= torque_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               if (!issued_ff) begin
                  issued_ff <= 1'b1;
               end else if (alu_stat.done) begin
                  issued_ff <= 1'b0;
                  case (state_ff)
                     ST_NL_MUL:  state_ff <= ST_NL_DIV;
                     ST_NL_DIV:  state_ff <= ST_RAD_MUL;
                     ST_RAD_MUL: begin
                        omega_ff <= omega_cap;
                        state_ff <= torque_on ? ST_STL_MUL : ST_T1K_MUL;
                     end
                     ST_STL_MUL: state_ff <= ST_STL_DIV;
                     ST_STL_DIV: begin
                        stallv_ff <= stallv_cap;
                        state_ff  <= ST_RT_DIV;
                     end
                     ST_RT_DIV:  state_ff <= ST_MAG_MUL;
                     ST_MAG_MUL: begin
                        mag_ff    <= res[FRAC_BITS+30:FRAC_BITS];
                        torque_ff <= vneg_ff ? -$signed({1'b0, res[FRAC_BITS+30:FRAC_BITS]})
                                             : $signed({1'b0, res[FRAC_BITS+30:FRAC_BITS]});
                        state_ff  <= ST_T1K_MUL;
                     end
                     ST_T1K_MUL: state_ff <= ST_TTS_MUL;
                     ST_TTS_MUL: begin
                        spd_ff   <= spd_sat;
                        state_ff <= ST_DMP_MUL;
                     end
                     ST_DMP_MUL: begin
                        speed_ff <= dmp_clamped;
                        state_ff <= ST_ANG_MUL;
                     end
                     ST_ANG_MUL: begin
                        angle_ff <= speed_ff[OUT_W-1] ? (angle_ff - frac_p)
                                                      : (angle_ff + frac_p);
                        state_ff <= ST_DONE;
                     end
                     ST_CST_MUL: begin
                        speed_ff <= speed_ff[OUT_W-1] ? -$signed(frac_p) : $signed(frac_p);
                        state_ff <= ST_DONE;
                     end
                     default: state_ff <= ST_IDLE;
                  endcase
               end
            end
         endcase
      end
   end

   // shared unit is only started when free
   assert property (@(posedge clock) disable iff (reset)
      alu_req.start |-> !alu_stat.busy)
      else $error("shared unit started while busy");

   // no operation is left running once the sequencer is idle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !alu_stat.busy)
      else $error("shared unit busy while sequencer idle");

   // a disabled step goes straight to the response
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && !cfg.enable) |=> (state_ff == ST_DONE) && $stable(speed_ff))
      else $error("disabled step touched the motor state");

   // speed never exceeds the no-load limit after a driven step
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ANG_MUL) |->
         ($signed({speed_ff[OUT_W-1], speed_ff}) <= $signed({2'b00, omega_ff})))
      else $error("speed above no-load limit");

endmodule

// File: rtl/core/dcm_csr.sv
// Configuration registers of the DC motor step unit.
module dcm_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [dcm_pkg::CSR_IW-1:0]   csr_index,
   input  logic [dcm_pkg::CSR_DW-1:0]   csr_wdata,
   output dcm_pkg::cfg_type             cfg
);
   import dcm_pkg::*;

   cfg_type cfg_ff;

   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable            <= 1'b0;
         cfg_ff.rated_voltage     <= RATED_V_RST;
         cfg_ff.no_load_speed_rpm <= RPM_RST;
         cfg_ff.stall_nm          <= STALL_RST;
         cfg_ff.time_step         <= TSTEP_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_ENABLE:    cfg_ff.enable            <= csr_wdata[0];
            CSR_RATED_V:   cfg_ff.rated_voltage     <= csr_wdata[RV_W-1:0];
            CSR_NL_RPM:    cfg_ff.no_load_speed_rpm <= csr_wdata[RPM_W-1:0];
            CSR_STALL:     cfg_ff.stall_nm          <= csr_wdata[ST_W-1:0];
            CSR_TIME_STEP: cfg_ff.time_step         <= csr_wdata[TS_W-1:0];
            default: ;   // unmapped index: ignored
         endcase
      end
   end

endmodule

// File: rtl/core/dcm_alu.sv
// Shared bit-serial unit: shift-add multiply and restoring divide, one bit a cycle.
module dcm_alu (
   input  logic                  clock,
   input  logic                  reset,
   input  dcm_pkg::alu_req_type  req,
   output dcm_pkg::alu_stat_type stat
);
   import dcm_pkg::*;

   logic [ALU_W-1:0] acc_ff, acc_in;     // product / remainder
   logic [ALU_W-1:0] sh_ff, sh_in;       // multiplier / dividend then quotient
   logic [ALU_W-1:0] opnd_ff, opnd_in;   // multiplicand / divisor
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   alu_op_type       op_ff;

   logic [ALU_W-1:0] trial;
   logic [ALU_W-1:0] base;
   logic [ALU_W-1:0] addend;
   logic [ALU_W:0]   sum;
   logic             is_div;

   // one adder serves both ops; carry out on divide means no borrow
   always_comb begin
      is_div = (op_ff == ALU_DIV);
      trial  = {acc_ff[ALU_W-2:0], sh_ff[ALU_W-1]};
      base   = is_div ? trial : acc_ff;
      addend = is_div ? ~opnd_ff : (sh_ff[0] ? opnd_ff : '0);
      sum    = {1'b0, base} + {1'b0, addend} + {{ALU_W{1'b0}}, is_div};
      if (is_div) begin
         acc_in  = sum[ALU_W] ? sum[ALU_W-1:0] : trial;
         sh_in   = {sh_ff[ALU_W-2:0], sum[ALU_W]};
         opnd_in = opnd_ff;
      end else begin
         acc_in  = sum[ALU_W-1:0];
         sh_in   = {1'b0, sh_ff[ALU_W-1:1]};
         opnd_in = {opnd_ff[ALU_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= req.nbits;
            op_ff   <= req.op;
            acc_ff  <= '0;
            sh_ff   <= (req.op == ALU_DIV) ? req.x : req.y;
            opnd_ff <= (req.op == ALU_DIV) ? req.y : req.x;
         end else if (busy_ff) begin
            acc_ff  <= acc_in;
            sh_ff   <= sh_in;
            opnd_ff <= opnd_in;
            cnt_ff  <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign stat.busy   = busy_ff;
   assign stat.done   = done_ff;
   assign stat.result = (op_ff == ALU_DIV) ? sh_ff : acc_ff;

endmodule
